FILE: src/avfdd_pkg.sv
// Shared types and constants for the frame deframer and descrambler.
`timescale 1ns / 1ps

package avfdd_pkg;

   localparam int WORD_W      = 32;
   localparam int HDR_LEN_LSB = 12;
   localparam int HDR_LEN_MAX = WORD_W - HDR_LEN_LSB;
   localparam int HDR_BYTES   = 12;
   localparam int HDR_CNT_W   = 4;
   localparam int KP_W        = 3;
   localparam int KEY_W       = 64;
   localparam int VLEN_W      = 21;
   localparam int ALEN_W      = 20;
   localparam int CSR_IDX_W   = 2;

   localparam logic [HDR_CNT_W-1:0] HDR_STAMP_CLR = 4'd7;
   localparam logic [HDR_CNT_W-1:0] HDR_STAMP_LO  = 4'd8;
   localparam logic [HDR_CNT_W-1:0] HDR_WORD_END  = 4'd4;
   localparam logic [HDR_CNT_W-1:0] HDR_LAST      = 4'(HDR_BYTES - 1);

   localparam logic [VLEN_W-1:0] MAX_VIDEO_RESET = 21'd1048576;
   localparam logic [ALEN_W-1:0] MAX_AUDIO_RESET = 20'd1024;

   localparam logic [CSR_IDX_W-1:0] CSR_MASK_KEY      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VIDEO_LEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_AUDIO_LEN = 2'd2;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [1:0] ERR_BAD_TYPE  = 2'd0;
   localparam logic [1:0] ERR_VIDEO_LEN = 2'd1;
   localparam logic [1:0] ERR_AUDIO_LEN = 2'd2;

   localparam logic [1:0] TYPE_VIDEO = 2'd0;
   localparam logic [1:0] TYPE_AUDIO = 2'd1;

   typedef enum logic {
      PHASE_HEADER  = 1'b0,
      PHASE_PAYLOAD = 1'b1
   } phase_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [7:0]        out_byte;
      logic              stream_id;
      logic [WORD_W-1:0] frame_time;
      logic              last;
      logic [1:0]        error_code;
   } rsp_type;

endpackage

FILE: src/av_frame_deframer_descrambler_core.sv
// Frame deframer and descrambler: header parse, length check and payload XOR.
`timescale 1ns / 1ps

// The block takes one stream byte per cycle while req_ready is high and gives
// at most one result word per byte, held in the output or skid register.
// Header collection, the frame verdict on the twelfth header byte, and the key
// XOR of payload bytes are all combinational ahead of the output register.
// Results go through an output register backed by one skid register, so bytes
// keep flowing at one per cycle while rsp_ready is high. After rsp_ready drops,
// bytes are still taken until a result word is waiting in the skid register.
// Configuration writes are taken in any cycle (csr_ready is always high) and
// take effect for the next byte.
module av_frame_deframer_descrambler_core
   import avfdd_pkg::*;
#(
   parameter int KEY_BYTES = 8,
   parameter int LEN_BITS  = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_in_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_kind,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_stream_id,
   output logic [WORD_W-1:0]    rsp_frame_time,
   output logic                 rsp_last,
   output logic [1:0]           rsp_error_code,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEY_W-1:0]     csr_wdata
);

   localparam int LEN_W = (LEN_BITS < HDR_LEN_MAX) ? LEN_BITS : HDR_LEN_MAX;

   logic [KEY_W-1:0]     mask_key_ff;
   logic [VLEN_W-1:0]    max_video_ff;
   logic [ALEN_W-1:0]    max_audio_ff;

   phase_type            phase_ff, phase_in;
   logic [HDR_CNT_W-1:0] header_count_ff, header_count_in;
   logic [WORD_W-1:0]    header_word_ff, header_word_in;
   logic [WORD_W-1:0]    stamp_ff, stamp_in;
   logic [LEN_W-1:0]     bytes_left_ff, bytes_left_in;
   logic [KP_W-1:0]      key_phase_ff, key_phase_in;
   logic                 stream_ff, stream_in;

   rsp_type              out_ff, skid_ff, res;
   logic                 out_valid_ff, skid_valid_ff, res_valid;

   logic                 req_fire;
   logic                 out_free;
   logic [KP_W:0]        kp_sum;
   logic [7:0]           key_byte;
   logic [1:0]           hdr_type;
   logic [LEN_W-1:0]     hdr_len;

   assign csr_ready = 1'b1;
   assign req_ready = !skid_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;

   assign kp_sum   = (KP_W+1)'(key_phase_ff) + (KP_W+1)'(1);
   assign key_byte = mask_key_ff[{key_phase_ff, 3'b000} +: 8];
   assign hdr_type = header_word_ff[1:0];
   assign hdr_len  = header_word_ff[HDR_LEN_LSB +: LEN_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_key_ff  <= '0;
         max_video_ff <= MAX_VIDEO_RESET;
         max_audio_ff <= MAX_AUDIO_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MASK_KEY:      mask_key_ff  <= csr_wdata;
            CSR_MAX_VIDEO_LEN: max_video_ff <= csr_wdata[VLEN_W-1:0];
            CSR_MAX_AUDIO_LEN: max_audio_ff <= csr_wdata[ALEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PHASE_HEADER;
         header_count_ff <= '0;
         header_word_ff  <= '0;
         stamp_ff        <= '0;
         bytes_left_ff   <= '0;
         key_phase_ff    <= '0;
         stream_ff       <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         header_word_ff  <= header_word_in;
         stamp_ff        <= stamp_in;
         bytes_left_ff   <= bytes_left_in;
         key_phase_ff    <= key_phase_in;
         stream_ff       <= stream_in;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      header_word_in  = header_word_ff;
      stamp_in        = stamp_ff;
      bytes_left_in   = bytes_left_ff;
      key_phase_in    = key_phase_ff;
      stream_in       = stream_ff;
      res_valid       = 1'b0;
      res             = '0;
      if (req_fire) begin
         case (phase_ff)
            PHASE_PAYLOAD: begin
               key_phase_in  = (kp_sum >= (KP_W+1)'(KEY_BYTES)) ? '0 : kp_sum[KP_W-1:0];
               bytes_left_in = bytes_left_ff - LEN_W'(1);
               res_valid     = 1'b1;
               res.kind      = KIND_DATA;
               res.out_byte  = req_in_byte ^ key_byte;
               res.stream_id = stream_ff;
               res.last      = (bytes_left_ff == LEN_W'(1));
               if (res.last) begin
                  phase_in = PHASE_HEADER;
               end
            end
            default: begin
               if (header_count_ff < HDR_WORD_END) begin
                  header_word_in[{header_count_ff[1:0], 3'b000} +: 8] = req_in_byte;
               end else if (header_count_ff >= HDR_STAMP_LO) begin
                  stamp_in[{header_count_ff[1:0], 3'b000} +: 8] = req_in_byte;
               end
               if (header_count_ff == HDR_STAMP_CLR) begin
                  stamp_in = '0;
               end
               if (header_count_ff == HDR_LAST) begin
                  header_count_in = '0;
                  header_word_in  = '0;
                  res_valid       = 1'b1;
                  res.last        = 1'b1;
                  if (hdr_type[1]) begin
                     res.kind       = KIND_ERROR;
                     res.stream_id  = hdr_type[0];
                     res.error_code = ERR_BAD_TYPE;
                  end else if (hdr_type == TYPE_VIDEO &&
                               VLEN_W'(hdr_len) > max_video_ff) begin
                     res.kind       = KIND_ERROR;
                     res.stream_id  = 1'b0;
                     res.error_code = ERR_VIDEO_LEN;
                  end else if (hdr_type == TYPE_AUDIO &&
                               VLEN_W'(hdr_len) > VLEN_W'(max_audio_ff)) begin
                     res.kind       = KIND_ERROR;
                     res.stream_id  = 1'b1;
                     res.error_code = ERR_AUDIO_LEN;
                  end else begin
                     stream_in     = hdr_type[0];
                     key_phase_in  = '0;
                     res.stream_id = hdr_type[0];
                     if (hdr_len == '0) begin
                        res.kind = KIND_EMPTY;
                     end else begin
                        res_valid     = 1'b0;
                        bytes_left_in = hdr_len;
                        phase_in      = PHASE_PAYLOAD;
                     end
                  end
               end else begin
                  header_count_in = header_count_ff + HDR_CNT_W'(1);
               end
            end
         endcase
      end
      res.frame_time = stamp_in;
   end

   // Hold results in the output word, overflow into the skid word on a stall.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= res_valid;
         end else begin
            out_valid_ff  <= res_valid;
         end
      end else if (res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
            if (res_valid) begin
               skid_ff <= res;
            end
         end else if (res_valid) begin
            out_ff <= res;
         end
      end else if (res_valid) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_ff.kind;
   assign rsp_out_byte   = out_ff.out_byte;
   assign rsp_stream_id  = out_ff.stream_id;
   assign rsp_frame_time = out_ff.frame_time;
   assign rsp_last       = out_ff.last;
   assign rsp_error_code = out_ff.error_code;

endmodule
